/* hdl/pcx_pkg.sv */
package pcx_pkg;

  // Key derivation and key roll constants.
  localparam logic [31:0] KeyMixA  = 32'h9C30_D539;
  localparam logic [31:0] KeyMixB  = 32'h930F_D7E2;
  localparam logic [31:0] KeyMixC  = 32'h7C72_E993;
  localparam logic [31:0] KeyStep  = 32'h287E_FFC3;
  localparam int unsigned SeedRotR = 13;

  // Largest number of result bytes one input item can release.
  localparam int unsigned MaxResults = 4;
  localparam int unsigned ResIdxW    = $clog2(MaxResults);

  // Default number of result groups held between the front and the back.
  localparam int unsigned QueueDepthDef = 4;

  typedef enum logic [1:0] {
    OP_DECRYPT = 2'd0,
    OP_ENCRYPT = 2'd1,
    OP_INIT    = 2'd2
  } op_e;

  // One group of result bytes produced by a single input item.
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [ResIdxW-1:0]         cnt_m1;     // number of bytes minus one
    logic                       last;       // final byte of the group ends the packet
    logic                       short_pkt;  // packet under four bytes, passed unchanged
  } group_t;

  function automatic logic [63:0] roll_key(input logic [63:0] key, input logic [31:0] mask);
    logic [31:0] lo;
    logic [31:0] hi;
    lo = key[31:0] ^ mask;
    hi = key[63:32] + KeyStep;
    return {hi, lo};
  endfunction

endpackage

/* hdl/pcx_front.sv */
module pcx_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  seed_we_i,
  input  logic [31:0]           seed_value_i,
  input  logic                  accept_i,
  input  logic [1:0]            opcode_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  output logic                  group_valid_o,
  output pcx_pkg::group_t       group_o
);
  import pcx_pkg::*;

  logic [31:0] seed_q;
  logic [63:0] recv_key_q, recv_key_d;
  logic [63:0] send_key_q, send_key_d;
  logic        ready_q, ready_d;
  logic [2:0]  idx_q, idx_d;
  logic        head_done_q, head_done_d;
  logic [7:0]  chain_q, chain_d;
  logic [31:0] mask_q, mask_d;
  logic [7:0]  head_q [3];
  logic [7:0]  head_d [3];

  op_e         op;
  logic [63:0] key;
  logic [7:0]  kb [8];
  logic [31:0] s_mix, s_lo, s_hi;

  // Head mixing terms for both directions.
  logic [7:0]  c0, c1, c2, c3;
  logic [7:0]  dk, dd1, dd2, dd3, dr0, dr1, dr2, dr3;
  logic [7:0]  e0, e1, e2, e3, er0, er1, er2, er3;
  logic [7:0]  body_out;
  logic [63:0] rolled;
  logic [31:0] new_mask;

  assign op  = op_e'(opcode_i);
  assign key = (op == OP_DECRYPT) ? recv_key_q : send_key_q;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      kb[i] = key[8*i +: 8];
    end
  end

  assign s_mix = seed_q ^ KeyMixA;
  assign s_lo  = (s_mix >> SeedRotR) | (s_mix << (32 - SeedRotR));
  assign s_hi  = KeyMixB ^ s_lo ^ KeyMixC;

  assign c0 = head_q[0];
  assign c1 = head_q[1];
  assign c2 = head_q[2];
  assign c3 = data_byte_i;

  assign dk  = c0 ^ c1 ^ kb[5];
  assign dd1 = c1 ^ c2 ^ kb[4];
  assign dd2 = c2 ^ c3 ^ kb[3];
  assign dd3 = c3 ^ kb[2];
  assign dr0 = dk ^ kb[0];
  assign dr1 = dd1 ^ kb[1] ^ dk;
  assign dr2 = dd2 ^ kb[2] ^ dd1;
  assign dr3 = dd3 ^ kb[3] ^ dd2;

  assign e0  = c0 ^ kb[0];
  assign e1  = c1 ^ e0 ^ kb[1];
  assign e2  = c2 ^ e1 ^ kb[2];
  assign e3  = c3 ^ e2 ^ kb[3];
  assign er3 = e3 ^ kb[2];
  assign er2 = e2 ^ er3 ^ kb[3];
  assign er1 = e1 ^ er2 ^ kb[4];
  assign er0 = e0 ^ er1 ^ kb[5];

  assign body_out = data_byte_i ^ chain_q ^ kb[idx_q];

  always_comb begin
    recv_key_d    = recv_key_q;
    send_key_d    = send_key_q;
    ready_d       = ready_q;
    idx_d         = idx_q;
    head_done_d   = head_done_q;
    chain_d       = chain_q;
    mask_d        = mask_q;
    head_d        = head_q;
    group_valid_o = 1'b0;
    group_o       = '0;
    new_mask      = mask_q;
    rolled        = '0;

    case (op)
      OP_INIT: begin
        recv_key_d  = {s_hi, s_lo};
        send_key_d  = {s_hi, s_lo};
        ready_d     = 1'b1;
        idx_d       = '0;
        head_done_d = 1'b0;
        chain_d     = '0;
        mask_d      = '0;
      end
      OP_DECRYPT, OP_ENCRYPT: begin
        group_valid_o = 1'b1;
        if (!ready_q) begin
          // Keys not derived yet: the byte passes through untouched.
          group_o.bytes[0] = data_byte_i;
          group_o.last     = last_byte_i;
        end else if (!head_done_q && idx_q < 3'd3) begin
          for (int i = 0; i < 3; i++) begin
            if (idx_q == 3'(i)) begin
              head_d[i] = data_byte_i;
            end
          end
          group_valid_o = last_byte_i;
          if (!last_byte_i) begin
            idx_d = idx_q + 3'd1;
          end else begin
            // Short packet: release the buffered bytes unchanged.
            group_o.bytes[0]  = head_q[0];
            group_o.bytes[1]  = head_q[1];
            group_o.bytes[2]  = head_q[2];
            group_o.bytes[idx_q[1:0]] = data_byte_i;
            group_o.cnt_m1    = idx_q[1:0];
            group_o.last      = 1'b1;
            group_o.short_pkt = 1'b1;
            idx_d       = '0;
            head_done_d = 1'b0;
            chain_d     = '0;
            mask_d      = '0;
          end
        end else if (!head_done_q) begin
          // Fourth byte: mix and release the whole head.
          if (op == OP_DECRYPT) begin
            group_o.bytes = {dr3, dr2, dr1, dr0};
            chain_d       = dd3;
            new_mask      = {dr3, dr2, dr1, dr0};
          end else begin
            group_o.bytes = {er3, er2, er1, er0};
            chain_d       = e3;
            new_mask      = {c3, c2, c1, c0};
          end
          group_o.cnt_m1 = ResIdxW'(MaxResults - 1);
          group_o.last   = last_byte_i;
          mask_d         = new_mask;
          head_done_d    = 1'b1;
          idx_d          = 3'd4;
        end else begin
          group_o.bytes[0] = body_out;
          group_o.last     = last_byte_i;
          chain_d          = (op == OP_DECRYPT) ? data_byte_i : body_out;
          idx_d            = idx_q + 3'd1;
        end

        if (ready_q && last_byte_i && (head_done_q || idx_q == 3'd3)) begin
          rolled = roll_key(key, new_mask);
          if (op == OP_DECRYPT) begin
            recv_key_d = rolled;
          end else begin
            send_key_d = rolled;
          end
          idx_d       = '0;
          head_done_d = 1'b0;
          chain_d     = '0;
          mask_d      = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= '0;
      recv_key_q  <= '0;
      send_key_q  <= '0;
      ready_q     <= 1'b0;
      idx_q       <= '0;
      head_done_q <= 1'b0;
      chain_q     <= '0;
      mask_q      <= '0;
    end else begin
      if (seed_we_i) begin
        seed_q <= seed_value_i;
      end
      if (accept_i) begin
        recv_key_q  <= recv_key_d;
        send_key_q  <= send_key_d;
        ready_q     <= ready_d;
        idx_q       <= idx_d;
        head_done_q <= head_done_d;
        chain_q     <= chain_d;
        mask_q      <= mask_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      head_q <= head_d;
    end
  end

endmodule

/* hdl/pcx_queue.sv */
module pcx_queue #(
  parameter int unsigned Depth = pcx_pkg::QueueDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  pcx_pkg::group_t                wdata_i,
  input  logic                           pop_i,
  output pcx_pkg::group_t                rdata_o,
  output logic                           full_o,
  output logic                           empty_o,
  output logic [$clog2(Depth+1)-1:0]     level_o
);
  import pcx_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  group_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign level_o = cnt_q;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

/* hdl/pcx_back.sv */
module pcx_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pcx_pkg::group_t                   group_i,
  input  logic                              group_empty_i,
  output logic                              group_pop_o,
  input  logic                              pop_i,
  output logic [7:0]                        out_byte_o,
  output logic                              out_last_o,
  output logic                              short_packet_o,
  output logic [pcx_pkg::ResIdxW-1:0]       sub_o
);
  import pcx_pkg::*;

  logic [ResIdxW-1:0] sub_q, sub_d;
  logic               at_end;
  logic               take;

  assign at_end         = (sub_q == group_i.cnt_m1);
  assign take           = pop_i && !group_empty_i;
  assign group_pop_o    = take && at_end;
  assign out_byte_o     = group_i.bytes[sub_q];
  assign out_last_o     = group_i.last && at_end;
  assign short_packet_o = group_i.short_pkt;
  assign sub_o          = sub_q;

  always_comb begin
    sub_d = sub_q;
    if (take) begin
      sub_d = at_end ? '0 : sub_q + ResIdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= '0;
    end else begin
      sub_q <= sub_d;
    end
  end

endmodule

/* hdl/packet_chained_xor_cipher.sv */
// A byte that releases results writes its group into the result queue, which feeds the result ports.
// Throughput: one input transfer per cycle unless the queue is full and one result transfer per
// cycle unless it is empty; a packet's fourth byte releases four results, drained one per cycle from the group queue.
// Reset (rst_ni low, asynchronous) clears both keys, the initialized flag, the packet
// position, chain byte, head mask, seed register and the result queue.
module packet_chained_xor_cipher #(
  parameter int unsigned QueueDepth = pcx_pkg::QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       seed_we_i,
  input  logic [31:0] seed_value_i,
  input  logic       push,
  output logic       full,
  input  logic [1:0] opcode_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic       short_packet_o
);
  import pcx_pkg::*;

  localparam int unsigned LevelW = $clog2(QueueDepth + 1);

  // The front holds the keys and the packet position. It turns every transfer into
  // at most one group of result bytes, so its state advances one item per cycle while the queue is not full.
  logic              accept;
  logic              group_valid;
  group_t            group_in;

  // The queue keeps finished groups; the back splits each group into single
  // result transfers, so a stalled consumer never holds up the front until the
  // queue fills.
  group_t            group_head;
  logic              group_pop;
  logic [LevelW-1:0] level;
  logic [ResIdxW-1:0] sub;

  assign accept = push && !full;

  pcx_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .seed_we_i     (seed_we_i),
    .seed_value_i  (seed_value_i),
    .accept_i      (accept),
    .opcode_i      (opcode_i),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .group_valid_o (group_valid),
    .group_o       (group_in)
  );

  pcx_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && group_valid),
    .wdata_i (group_in),
    .pop_i   (group_pop),
    .rdata_o (group_head),
    .full_o  (full),
    .empty_o (empty),
    .level_o (level)
  );

  pcx_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .group_i        (group_head),
    .group_empty_i  (empty),
    .group_pop_o    (group_pop),
    .pop_i          (pop),
    .out_byte_o     (out_byte_o),
    .out_last_o     (out_last_o),
    .short_packet_o (short_packet_o),
    .sub_o          (sub)
  );

  // The queue never holds more groups than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= LevelW'(QueueDepth))
    else $error("result queue overflow");

  // The position inside the current group stays within that group's byte count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> sub <= group_head.cnt_m1)
    else $error("result position past end of group");

  // While nothing waits, the back sits at the start of a group.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty |-> sub == '0)
    else $error("result position not cleared with empty queue");

  // A short packet group always ends its packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && group_head.short_pkt) |-> group_head.last)
    else $error("short packet group without packet end");

endmodule
